// ===== hdl/tmps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle max path sum package
// Shared widths, defaults and the saturating sum helper.
// ----------------------------------------------------------------------------
package tmps_pkg;

    // field widths
    localparam int unsigned ENTRY_W     = 16;
    localparam int unsigned SUM_W       = 25;
    localparam int unsigned ROW_COUNT_W = 10;

    // padded stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 32;

    // default row store depth
    localparam int unsigned MAX_ROWS_DEFAULT = 512;

    // saturate a one-bit-grown sum back to SUM_W
    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] wide);
        logic [SUM_W-1:0] res;
        if (wide[SUM_W] != wide[SUM_W-1]) begin
            res = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            res = wide[SUM_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/triangle_max_path_sum_unit.sv =====
`timescale 1ns / 1ps
// Latency: a triangle's result is valid on m_tvalid in the cycle after its last entry is accepted.
// Throughput: one entry per cycle, set by the single-port-read row store that is
// re-read every cycle at the upcoming column, with a write-to-read bypass.
// A result stalled on m_tready blocks input only at an entry that ends a triangle.
// Reset (aresetn, synchronous, active low) returns to row 1, column 1, row_count 1;
// the row store is not cleared.
// ----------------------------------------------------------------------------
// Triangle max path sum unit
// Streams a number triangle row by row, keeps one row of best path sums in
// a memory updated in place, and emits the best bottom-row sum per triangle.
// ----------------------------------------------------------------------------
module triangle_max_path_sum_unit #(
    parameter int unsigned MAX_ROWS = tmps_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write: row_count
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tmps_pkg::ROW_COUNT_W-1:0]  cfg_data,
    // entry requests; tdata: [15:0] entry_value
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tmps_pkg::S_TDATA_W-1:0]    s_tdata,
    // result requests; tdata: [24:0] best_sum, [31:25] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tmps_pkg::M_TDATA_W-1:0]    m_tdata
);
    import tmps_pkg::*;

    localparam int unsigned AW   = $clog2(MAX_ROWS);
    localparam int unsigned CMPW = (AW + 1 > ROW_COUNT_W) ? AW + 1 : ROW_COUNT_W;

    // position and configuration state (0-based row and column)
    logic [AW-1:0]    row0_reg, row0_next;
    logic [AW-1:0]    col0_reg, col0_next;
    logic [AW-1:0]    last_row0_reg;
    logic [SUM_W-1:0] left_old_reg, running_best_reg, running_best_next;
    logic             m_valid_reg;
    logic [SUM_W-1:0] m_sum_reg;

    // row store and its read path
    logic [SUM_W-1:0] row_mem [MAX_ROWS];
    logic [SUM_W-1:0] rd_data_reg;
    logic             fwd_reg;
    logic [SUM_W-1:0] fwd_data_reg;

    logic             s_accept;
    logic             row_end;
    logic             tri_end;
    logic [SUM_W-1:0] old_here;
    logic [SUM_W-1:0] up_sum;
    logic [SUM_W-1:0] entry_ext;
    logic [SUM_W-1:0] sum_val;
    logic [CMPW-1:0]  cfg_ext;

    assign cfg_ready = 1'b1;

    assign row_end  = (col0_reg >= row0_reg);
    assign tri_end  = row_end && (row0_reg >= last_row0_reg);
    // only an entry that produces a result needs the output slot
    assign s_tready = !tri_end || !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // old sum for the current column, bypassing a same-cycle write
    assign old_here = fwd_reg ? fwd_data_reg : rd_data_reg;

    // pick upper neighbor(s)
    always_comb begin
        if (col0_reg == '0) begin
            up_sum = old_here;
        end else if (col0_reg >= row0_reg) begin
            up_sum = left_old_reg;
        end else begin
            up_sum = ($signed(left_old_reg) > $signed(old_here)) ? left_old_reg : old_here;
        end
    end

    assign entry_ext = {{(SUM_W-ENTRY_W){s_tdata[ENTRY_W-1]}}, s_tdata[ENTRY_W-1:0]};

    // entry plus best upper sum, saturated; top row takes the entry alone
    always_comb begin
        if (row0_reg == '0) begin
            sum_val = entry_ext;
        end else begin
            sum_val = sat_sum({up_sum[SUM_W-1], up_sum} + {entry_ext[SUM_W-1], entry_ext});
        end
    end

    // row best tracking and position advance
    always_comb begin
        running_best_next = running_best_reg;
        row0_next         = row0_reg;
        col0_next         = col0_reg;
        if (s_accept) begin
            if (col0_reg == '0 || $signed(sum_val) > $signed(running_best_reg)) begin
                running_best_next = sum_val;
            end
            if (tri_end) begin
                row0_next = '0;
                col0_next = '0;
            end else if (row_end) begin
                row0_next = row0_reg + 1'b1;
                col0_next = '0;
            end else begin
                col0_next = col0_reg + 1'b1;
            end
        end
    end

    // row count saturated to the store depth, kept as a 0-based last row
    assign cfg_ext = CMPW'(cfg_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg         <= '0;
            col0_reg         <= '0;
            last_row0_reg    <= '0;
            left_old_reg     <= '0;
            running_best_reg <= '0;
            m_valid_reg      <= 1'b0;
            fwd_reg          <= 1'b0;
        end else begin
            row0_reg         <= row0_next;
            col0_reg         <= col0_next;
            running_best_reg <= running_best_next;
            if (s_accept) begin
                left_old_reg <= old_here;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_ext == '0) begin
                    last_row0_reg <= '0;
                end else if (cfg_ext > CMPW'(MAX_ROWS)) begin
                    last_row0_reg <= AW'(MAX_ROWS - 1);
                end else begin
                    last_row0_reg <= AW'(cfg_ext - 1'b1);
                end
            end
            // output slot
            if (s_accept && tri_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            fwd_reg <= s_accept && (col0_reg == col0_next);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept && tri_end) begin
            m_sum_reg <= running_best_next;
        end
        fwd_data_reg <= sum_val;
    end

    // row store: write the new sum, read the upcoming column every cycle
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            row_mem[col0_reg] <= sum_val;
        end
        rd_data_reg <= row_mem[col0_next];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-SUM_W){1'b0}}, m_sum_reg};

`ifndef SYNTH
    // column never runs past the current row
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        col0_reg <= row0_reg)
        else $error("column beyond row");

    // a finishing entry loads the output slot
    a_end_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && tri_end |=> m_valid_reg)
        else $error("result not registered");

    // a finishing entry restarts at the apex
    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && tri_end |=> (row0_reg == '0) && (col0_reg == '0))
        else $error("triangle did not restart");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_accept && tri_end && m_valid_reg && !m_tready))
        else $error("result overwritten");
`endif

endmodule

// ===== tb/sv/tmps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle max path sum checker
// Watches the config, entry and result channels, rebuilds the best path sums
// row by row and checks every result request against the oldest expected sum.
// ----------------------------------------------------------------------------
module tmps_checker #(
    parameter int unsigned MAX_ROWS = tmps_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tmps_pkg::ROW_COUNT_W-1:0] cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // tdata: [15:0] entry_value
    input  logic [tmps_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: [24:0] best_sum, [31:25] zero
    input  logic [tmps_pkg::M_TDATA_W-1:0]   m_tdata,
    output int                               fail_count,
    output int                               pending_cnt,
    output int                               result_count,
    output int                               entry_count
);
    import tmps_pkg::*;

    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;

    localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(64'sd1 <<< (SUM_W - 1));

    // predicted state
    sum_t                    path_row [MAX_ROWS];
    int unsigned             row_at;
    int unsigned             col_at;
    sum_t                    left_prev;
    sum_t                    row_best;
    logic [ROW_COUNT_W-1:0]  rows_cfg;
    sum_t                    best_sum_q [$];

    // fold one entry into the row of best sums; returns 1 when a triangle ends
    function automatic bit absorb_entry(input entry_t v, output sum_t finished);
        int unsigned eff;
        int unsigned slot;
        sum_t        here;
        sum_t        up;
        sum_t        sum;
        longint      wide;
        bit          done;
        eff  = (rows_cfg == 0) ? 1 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        slot = (col_at >= 1 && col_at <= MAX_ROWS) ? col_at - 1 : 0;
        here = path_row[slot];
        if (row_at <= 1) begin
            sum = sum_t'(v);
        end else begin
            // left edge has only the upper-right parent, right edge only the upper-left
            if (col_at > 1 && col_at < row_at) begin
                up = (left_prev > here) ? left_prev : here;
            end else if (col_at > 1) begin
                up = left_prev;
            end else begin
                up = here;
            end
            wide = longint'(up) + longint'(v);
            if (wide > SUM_HI) wide = SUM_HI;
            if (wide < SUM_LO) wide = SUM_LO;
            sum = wide[SUM_W-1:0];
        end
        left_prev      = here;
        path_row[slot] = sum;
        if (col_at <= 1 || sum > row_best) row_best = sum;
        finished = row_best;
        done     = 1'b0;
        if (col_at >= row_at) begin
            if (row_at >= eff) begin
                done   = 1'b1;
                row_at = 1;
            end else begin
                row_at = row_at + 1;
            end
            col_at = 1;
        end else begin
            col_at = col_at + 1;
        end
        return done;
    endfunction

    // sample all three channels at the rising edge
    always @(posedge aclk) begin
        sum_t exp_sum;
        sum_t got_sum;
        sum_t fin;
        if (!aresetn) begin
            foreach (path_row[k]) path_row[k] = '0;
            row_at       = 1;
            col_at       = 1;
            left_prev    = '0;
            row_best     = '0;
            rows_cfg     = 1;
            best_sum_q.delete();
            fail_count   = 0;
            pending_cnt  = 0;
            result_count = 0;
            entry_count  = 0;
        end else begin
            // result request: compare with the oldest expected sum
            if (m_tvalid && m_tready) begin
                got_sum      = m_tdata[SUM_W-1:0];
                result_count = result_count + 1;
                if (best_sum_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result request, best_sum %0d",
                                 $realtime, got_sum);
                    fail_count = fail_count + 1;
                end else begin
                    exp_sum = best_sum_q.pop_front();
                    if (m_tdata !== {{(M_TDATA_W-SUM_W){1'b0}}, exp_sum}) begin
                        if (fail_count < 10)
                            $display("%0t: best_sum mismatch: expected %0d (0x%08h) got %0d (0x%08h)",
                                     $realtime, exp_sum,
                                     {{(M_TDATA_W-SUM_W){1'b0}}, exp_sum}, got_sum, m_tdata);
                        fail_count = fail_count + 1;
                    end
                end
            end

            // entry request: advance the prediction
            if (s_tvalid && s_tready) begin
                entry_count = entry_count + 1;
                if (absorb_entry(entry_t'(s_tdata[ENTRY_W-1:0]), fin))
                    best_sum_q.push_back(fin);
            end

            // a row count write takes effect after this edge
            if (cfg_valid && cfg_ready) rows_cfg = cfg_data;

            pending_cnt = best_sum_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle max path sum testbench
// Streams directed and random number triangles through the unit under
// changing row counts and idle/stall mixes; the checker predicts each result.
// ----------------------------------------------------------------------------
module tb;
    import tmps_pkg::*;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_t;

    localparam int unsigned ROWS_MAX      = MAX_ROWS_DEFAULT;
    localparam int          RUN_LIMIT     = 1_500_000;
    localparam int unsigned PHASE_ENTRIES = 220;
    localparam int unsigned EXTREME_ROWS  = 12;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned IDLE_MIX  [4] = '{0, 62, 0, 34};
    localparam int unsigned STALL_MIX [4] = '{0, 0, 62, 34};

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [ROW_COUNT_W-1:0]  cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    // tdata: [15:0] entry_value
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    // tdata: [24:0] best_sum, [31:25] zero
    logic [M_TDATA_W-1:0]    m_tdata;

    int          fail_count;
    int          pending_cnt;
    int          result_count;
    int          entry_count;
    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned hold_seq   = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int          cycle_count = 0;

    always #5 aclk = ~aclk;

    triangle_max_path_sum_unit #(
        .MAX_ROWS (ROWS_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tmps_checker #(
        .MAX_ROWS (ROWS_MAX)
    ) chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending_cnt  (pending_cnt),
        .result_count (result_count),
        .entry_count  (entry_count)
    );

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= stall_pct);
        end
    end

    // mostly uniform entries, with the extremes and zero/minus-one mixed in
    function automatic entry_t rand_entry();
        case ($urandom_range(19))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            default: return entry_t'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // one entry request, preceded by random idle cycles; returns at a falling edge
    task automatic send_entry(input entry_t v);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // drop the entry stream and wait until every expected result has come
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_cnt != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_rows(input int unsigned rows);
        cfg_valid <= 1'b1;
        cfg_data  <= rows[ROW_COUNT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // whole triangles for a given row count setting
    task automatic fill_triangles(input int unsigned rows, input int unsigned count,
                                  input fill_t fill, inout int unsigned sent);
        int unsigned eff;
        int unsigned n;
        eff = (rows == 0) ? 1 : (rows > ROWS_MAX) ? ROWS_MAX : rows;
        n   = eff * (eff + 1) / 2;
        repeat (count) begin
            for (int unsigned k = 0; k < n; k++) begin
                case (fill)
                    FILL_MAX: send_entry(16'sh7FFF);
                    FILL_MIN: send_entry(16'sh8000);
                    default:  send_entry(rand_entry());
                endcase
            end
            sent += n;
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned rows;
        int unsigned pick;

        sent = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset row count of one: each entry is its own triangle
        send_entry(16'sh7FFF);
        send_entry(16'sh8000);

        // row count zero behaves as one
        wait_idle();
        write_rows(0);
        send_entry(16'sh0000);
        send_entry(16'shFFFF);

        // three rows: left/right edges and interior max choice
        wait_idle();
        write_rows(3);
        send_entry(16'sd5);
        send_entry(16'sh8000);
        send_entry(16'sh7FFF);
        send_entry(16'sd1);
        send_entry(-16'sd2);
        send_entry(16'sd3);
        // all negative, best row sum is in the first column
        send_entry(-16'sd5);
        send_entry(-16'sd1);
        send_entry(-16'sd7);
        send_entry(-16'sd3);
        send_entry(16'sh8000);
        send_entry(-16'sd9);

        // two rows, alternating bit patterns
        wait_idle();
        write_rows(2);
        send_entry(16'sd10);
        send_entry(16'sh5555);
        send_entry(16'shAAAA);

        // long result hold-off with one-row triangles so the input backs up
        wait_idle();
        write_rows(1);
        hold_seq = hold_seq + 1;
        repeat (24) send_entry(rand_entry());
        wait_idle();

        // random triangles under each idle/stall mix
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = IDLE_MIX[ph];
            stall_pct = STALL_MIX[ph];
            sent      = 0;
            while (sent < PHASE_ENTRIES) begin
                pick = $urandom_range(99);
                if (pick < 5)
                    rows = 0;
                else if (pick < 70)
                    rows = $urandom_range(1, 6);
                else if (pick < 95)
                    rows = $urandom_range(7, 12);
                else
                    rows = $urandom_range(13, 24);
                wait_idle();
                write_rows(rows);
                fill_triangles(rows, $urandom_range(1, 4), FILL_RANDOM, sent);
            end
        end

        // deep triangles at the sum extremes
        idle_pct  = 0;
        stall_pct = 0;
        wait_idle();
        write_rows(EXTREME_ROWS);
        fill_triangles(EXTREME_ROWS, 1, FILL_MAX, sent);
        wait_idle();
        fill_triangles(EXTREME_ROWS, 1, FILL_MIN, sent);

        wait_idle();
        repeat (8) @(posedge aclk);

        $display("Covered %0d entries and %0d triangle results, row counts 0 to 24",
                 entry_count, result_count);
        $display("including all-max and all-min triangles, four idle/stall mixes and a result hold-off.");
        if (fail_count == 0 && pending_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
